// File: rtl/dgsm_pkg.sv
// Shared types and constants for the delta-gamma stream matcher.
// Used by the alignment cells, the output stage and the top level; depends on nothing.
`default_nettype none

package dgsm_pkg;

    localparam int LEN_W      = 5;
    localparam int DELTA_W    = 8;
    localparam int GAMMA_W    = 13;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 32;
    localparam int PAT_BITS   = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_DELTA          = 3'd3,
        CFG_GAMMA          = 3'd4
    } t_cfg_index;

    // Per-cell control: update strobe and whether the alignment is in use.
    typedef struct packed {
        logic enable;
        logic active;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/dgsm_cell.sv
// One alignment cell: running difference sum and failed mark for one alignment.
// Takes its state from the left neighbor each beat. Depends on dgsm_pkg.
`default_nettype none

module dgsm_cell
    import dgsm_pkg::*;
#(
    parameter int SYMBOL_BITS = 8,
    parameter int SCORE_W     = 13
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [SCORE_W-1:0]     i_prev_score,
    input  wire logic                   i_prev_failed,
    input  wire logic [SYMBOL_BITS-1:0] i_symbol,
    input  wire logic [SYMBOL_BITS-1:0] i_pattern,
    input  wire logic [DELTA_W-1:0]     i_delta,
    input  wire logic [SCORE_W-1:0]     i_limit,
    output logic [SCORE_W-1:0]          o_score,
    output logic                        o_failed,
    output logic                        o_failed_next
);

    localparam int DW = (SYMBOL_BITS > DELTA_W) ? SYMBOL_BITS : DELTA_W;

    logic [SCORE_W-1:0]     r_score;
    logic                   r_failed;
    logic [SCORE_W-1:0]     n_score;
    logic                   n_failed;
    logic [SYMBOL_BITS-1:0] diff;
    logic [SCORE_W-1:0]     sum;

    always_comb begin
        if (i_symbol >= i_pattern) begin
            diff = i_symbol - i_pattern;
        end else begin
            diff = i_pattern - i_symbol;
        end
        sum = i_prev_score + SCORE_W'(diff);
        n_failed = 1'b1;
        n_score  = '0;
        if (i_ctl.active && !i_prev_failed && (DW'(diff) <= DW'(i_delta))
                && (sum <= i_limit)) begin
            n_failed = 1'b0;
            n_score  = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b1;
        end else if (i_ctl.enable) begin
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.enable) begin
            r_score <= n_score;
        end
    end

    assign o_score       = r_score;
    assign o_failed      = r_failed;
    assign o_failed_next = n_failed;

    // An alignment outside the pattern length can never survive an update.
    a_inactive_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.enable && !i_ctl.active) |=> r_failed)
        else $error("inactive alignment left unfailed");

endmodule

`default_nettype wire

// File: rtl/dgsm_skid.sv
// Two-entry output stage that decouples the result channel from the input side.
// Upstream ready is a register. Depends on dgsm_pkg only for the house imports.
`default_nettype none

module dgsm_skid
    import dgsm_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_out_vld;
    logic             r_skid_vld;
    logic [WIDTH-1:0] r_out_data;
    logic [WIDTH-1:0] r_skid_data;
    logic             n_out_vld;
    logic             n_skid_vld;
    logic             load_out_in;
    logic             load_out_skid;
    logic             load_skid;

    always_comb begin
        n_out_vld     = r_out_vld;
        n_skid_vld    = r_skid_vld;
        load_out_in   = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                load_out_skid = 1'b1;
                n_out_vld     = 1'b1;
                n_skid_vld    = 1'b0;
            end else begin
                load_out_in = i_valid;
                n_out_vld   = i_valid;
            end
        end else if (i_valid && !r_skid_vld) begin
            // Output is stalled: park the new beat in the skid entry.
            load_skid  = 1'b1;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skid) begin
            r_out_data <= r_skid_data;
        end else if (load_out_in) begin
            r_out_data <= i_data;
        end
        if (load_skid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a beat while the output entry is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_ready) |=> (r_out_vld && !r_skid_vld))
        else $error("skid entry did not move into the output entry");

endmodule

`default_nettype wire

// File: rtl/delta_gamma_stream_matcher_core.sv
// Top level of the delta-gamma stream matcher: configuration registers, the
// row of alignment cells, the symbol counter and the output stage.
// Depends on dgsm_pkg, dgsm_cell and dgsm_skid.
//
// Usage: one text symbol enters per beat on the symbol channel (valid/ready).
// Each accepted beat shifts the row of alignment cells by one position and
// updates every alignment in the same cycle, so one symbol is taken per clock
// while the output stage has room. Each symbol yields exactly one result beat
// on the result channel: a match flag for the window that ends at this symbol
// and that window's start index (wrapping at 2^32). The result is registered
// in the output stage. A two-entry output stage absorbs one stalled result, so
// input ready drops only after the receiver has held off for two results.
// Configuration is written through a simple write port; the user must write it
// only while the block is idle, the block itself does not enforce this. Reset
// sets the registers to their defaults, marks every alignment failed, clears
// the symbol counter and empties the output stage.
`default_nettype none

module delta_gamma_stream_matcher_core
    import dgsm_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_symbol_valid,
    output logic                        o_symbol_ready,
    input  wire logic [SYMBOL_BITS-1:0] i_symbol_value,
    output logic                        o_result_valid,
    input  wire logic                   i_result_ready,
    output logic                        o_match_found,
    output logic [COUNT_W-1:0]          o_match_start
);

    localparam int SYM_MAX   = (1 << SYMBOL_BITS) - 1;
    localparam int GAMMA_MAX = (1 << (GAMMA_W - 1)) - 1;
    localparam int PROD_MAX  = MAX_PATTERN * SYM_MAX;
    localparam int LIMIT_MAX = (PROD_MAX > GAMMA_MAX) ? PROD_MAX : GAMMA_MAX;
    localparam int SCORE_W   = $clog2(LIMIT_MAX + SYM_MAX + 1);
    localparam int M_W       = $clog2(MAX_PATTERN + 1);
    localparam int CW        = (M_W > LEN_W) ? M_W : LEN_W;
    localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PROD_W    = M_W + DELTA_W;
    localparam int RES_W     = COUNT_W + 1;

    logic [LEN_W-1:0]      r_len;
    logic [PAT_BITS-1:0]   r_pattern;
    logic [DELTA_W-1:0]    r_delta;
    logic [GAMMA_W-1:0]    r_gamma;
    logic [COUNT_W-1:0]    r_seen;

    logic [M_W-1:0]        m;
    logic [PROD_W-1:0]     prod;
    logic [SCORE_W-1:0]    limit;
    logic                  accept;
    logic                  skid_ready;
    logic [IDX_W-1:0]      sel;
    logic                  match;
    logic [COUNT_W-1:0]    start;
    logic [RES_W-1:0]      res_data;

    logic [SCORE_W-1:0]     score   [MAX_PATTERN];
    logic                   failed  [MAX_PATTERN];
    logic                   fnext   [MAX_PATTERN];
    logic [SYMBOL_BITS-1:0] pat_sym [MAX_PATTERN];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(1);
            r_pattern <= '0;
            r_delta   <= '0;
            r_gamma   <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    r_pattern[PAT_BITS/2-1:0] <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern[PAT_BITS-1:PAT_BITS/2] <= i_cfg_data;
                CFG_DELTA:          r_delta <= i_cfg_data[DELTA_W-1:0];
                CFG_GAMMA:          r_gamma <= i_cfg_data[GAMMA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective pattern length: zero counts as one, large values saturate.
    always_comb begin
        if (r_len == '0) begin
            m = M_W'(1);
        end else if (CW'(r_len) > CW'(MAX_PATTERN)) begin
            m = M_W'(MAX_PATTERN);
        end else begin
            m = M_W'(r_len);
        end
        prod = PROD_W'(m) * PROD_W'(r_delta);
        // A negative gamma selects pattern length times delta.
        if (r_gamma[GAMMA_W-1]) begin
            limit = SCORE_W'(prod);
        end else begin
            limit = SCORE_W'(r_gamma[GAMMA_W-2:0]);
        end
    end

    assign accept = i_symbol_valid && skid_ready;

    genvar k, b;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            t_cell_ctl          ctl;
            logic [SCORE_W-1:0] prev_score;
            logic               prev_failed;

            for (b = 0; b < SYMBOL_BITS; b++) begin : g_bit
                localparam int POS = k * SYMBOL_BITS + b;
                if (POS < PAT_BITS) begin : g_in
                    assign pat_sym[k][b] = r_pattern[POS];
                end else begin : g_out
                    assign pat_sym[k][b] = 1'b0;
                end
            end

            // A fresh alignment enters at the first cell with a zero sum.
            if (k == 0) begin : g_head
                assign prev_score  = '0;
                assign prev_failed = 1'b0;
            end else begin : g_link
                assign prev_score  = score[k-1];
                assign prev_failed = failed[k-1];
            end

            assign ctl.enable = accept;
            assign ctl.active = (M_W'(k) < m);

            dgsm_cell #(
                .SYMBOL_BITS (SYMBOL_BITS),
                .SCORE_W     (SCORE_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_prev_score  (prev_score),
                .i_prev_failed (prev_failed),
                .i_symbol      (i_symbol_value),
                .i_pattern     (pat_sym[k]),
                .i_delta       (r_delta),
                .i_limit       (limit),
                .o_score       (score[k]),
                .o_failed      (failed[k]),
                .o_failed_next (fnext[k])
            );
        end
    endgenerate

    // The window ending at this symbol is the alignment in the last used cell.
    assign sel      = IDX_W'(m - M_W'(1));
    assign match    = !fnext[sel];
    assign start    = r_seen - COUNT_W'(m) + COUNT_W'(1);
    assign res_data = {match, start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            r_seen <= r_seen + COUNT_W'(1);
        end
    end

    dgsm_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_symbol_valid),
        .o_ready (skid_ready),
        .i_data  (res_data),
        .o_valid (o_result_valid),
        .i_ready (i_result_ready),
        .o_data  ({o_match_found, o_match_start})
    );

    assign o_symbol_ready = skid_ready;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_seen == $past(r_seen) + COUNT_W'(1)))
        else $error("symbol counter did not advance on an accepted beat");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_seen))
        else $error("symbol counter moved without an accepted beat");

endmodule

`default_nettype wire
